[design/skset_pkg.sv]
// Shared constants and types for the sorted key set.
package skset_pkg;

  // Item field widths on the stream ports
  localparam int OPCODE_W    = 2;
  localparam int KEY_W       = 16;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Default sizing
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_MEMBER = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

  // Result of one request
  typedef struct packed {
    logic               success;
    logic               full;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

[design/skset_mem.sv]
// Key store: one write port, one read port, registered read data.
module skset_mem #(
  parameter int CAPACITY = skset_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = skset_pkg::DEF_KEY_BITS,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [KEY_BITS-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [KEY_BITS-1:0] rdata
);

  logic [KEY_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/skset_ctrl.sv]
// Request sequencer: linear search, shift up or down, occupancy tracking.
module skset_ctrl #(
  parameter int CAPACITY = skset_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = skset_pkg::DEF_KEY_BITS,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [skset_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [skset_pkg::KEY_W-1:0]    in_key,
  output logic                          res_valid,
  input  logic                          res_ready,
  output skset_pkg::res_t               res,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [KEY_BITS-1:0]           mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [KEY_BITS-1:0]           mem_rdata
);

  localparam int KU = (KEY_BITS < skset_pkg::KEY_W) ? KEY_BITS : skset_pkg::KEY_W;
  localparam int EB = (CW < skset_pkg::COUNT_W) ? CW : skset_pkg::COUNT_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEARCH   = 7'b0000010,
    ST_DECIDE   = 7'b0000100,
    ST_SHIFT_UP = 7'b0001000,
    ST_PLACE    = 7'b0010000,
    ST_SHIFT_DN = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [skset_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [KEY_BITS-1:0]            key_r, key_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  pos_r, pos_nxt;
  logic                           found_r, found_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           success_r, success_nxt;
  logic                           full_r, full_nxt;

  logic [AW-1:0] idx_inc, idx_dec;
  logic [CW-1:0] idx_ext, cnt_last, pos_inc;

  assign idx_inc  = idx_r + AW'(1);
  assign idx_dec  = idx_r - AW'(1);
  assign idx_ext  = CW'(idx_r);
  assign cnt_last = cnt_r - CW'(1);
  assign pos_inc  = pos_r + CW'(1);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    cnt_nxt     = cnt_r;
    success_nxt = success_r;
    full_nxt    = full_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_inc;
    mem_wdata   = mem_rdata;
    mem_raddr   = idx_inc;

    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = '0;
        if (in_valid) begin
          op_nxt      = in_opcode;
          key_nxt     = KEY_BITS'(in_key[KU-1:0]);
          success_nxt = 1'b0;
          full_nxt    = 1'b0;
          idx_nxt     = '0;
          if (cnt_r == '0) begin
            pos_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_DECIDE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end

      // rdata holds entry idx_r; the next entry is always prefetched
      ST_SEARCH: begin
        if (mem_rdata >= key_r) begin
          pos_nxt   = idx_ext;
          found_nxt = (mem_rdata == key_r);
          state_nxt = ST_DECIDE;
        end else if (idx_ext == cnt_last) begin
          pos_nxt   = cnt_r;
          found_nxt = 1'b0;
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_FINISH;
        case (op_r)
          skset_pkg::OP_MEMBER: begin
            success_nxt = found_r;
          end
          skset_pkg::OP_INSERT: begin
            if (!found_r) begin
              if (cnt_r == CW'(CAPACITY)) begin
                full_nxt = 1'b1;
              end else if (pos_r == cnt_r) begin
                state_nxt = ST_PLACE;
              end else begin
                mem_raddr = AW'(cnt_last);
                idx_nxt   = AW'(cnt_last);
                state_nxt = ST_SHIFT_UP;
              end
            end
          end
          skset_pkg::OP_DELETE: begin
            if (found_r) begin
              if (pos_r == cnt_last) begin
                cnt_nxt     = cnt_last;
                success_nxt = 1'b1;
              end else begin
                mem_raddr = AW'(pos_inc);
                idx_nxt   = AW'(pos_inc);
                state_nxt = ST_SHIFT_DN;
              end
            end
          end
          default: begin
            success_nxt = 1'b0;
          end
        endcase
      end

      // move entry idx_r to idx_r+1, walking down toward pos
      ST_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc;
        mem_raddr = idx_dec;
        if (idx_ext == pos_r) begin
          state_nxt = ST_PLACE;
        end else begin
          idx_nxt = idx_dec;
        end
      end

      ST_PLACE: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(pos_r);
        mem_wdata   = key_r;
        cnt_nxt     = cnt_r + CW'(1);
        success_nxt = 1'b1;
        state_nxt   = ST_FINISH;
      end

      // move entry idx_r to idx_r-1, walking up to the last entry
      ST_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec;
        mem_raddr = idx_inc;
        if (idx_ext == cnt_last) begin
          cnt_nxt     = cnt_last;
          success_nxt = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.success = success_r;
  assign res.full    = full_r;
  assign res.count   = skset_pkg::COUNT_W'(cnt_r[EB-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    success_r <= success_nxt;
    full_r    <= full_nxt;
  end

endmodule

[design/sorted_key_set_core.sv]
// Sorted key set: top level with stream ports, output register and checks.
//
// Keeps up to CAPACITY distinct keys in ascending order in a single-port-write,
// single-port-read memory. One request item in, one result item out.
// Input item (in_tdata): opcode (member / insert / delete), then the key.
// Result item (out_tdata): success, full flag, entry count after the request.
// Steps per item, with n keys held:
//   accept, linear search over up to n entries (one entry per cycle,
//   bounded by the memory's registered read), decide, result.
//   Insert then shifts up to n entries up by one and writes the new key;
//   delete shifts up to n-1 entries down by one.
// One item is in flight at a time; in_tready is high only between items.
// The result sits in an output register, so the next item can be taken
// while the previous result still waits on out_tready. If the receiver
// stalls and the register is still full when the next result is ready,
// the sequencer holds that result and takes no new item.
// Reset (rst_n low, synchronous) empties the store and drops out_tvalid.
// Memory contents are not cleared; only entries below the count are read.
module sorted_key_set_core #(
  parameter int CAPACITY = skset_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = skset_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] opcode, [17:2] key, [23:18] zero
  input  logic [skset_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] success, [1] full_res, [8:2] entry_count, [15:9] zero
  output logic [skset_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                res_valid;
  logic                res_ready;
  skset_pkg::res_t     res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  logic            out_valid_r, out_valid_nxt;
  skset_pkg::res_t out_res_r, out_res_nxt;

  skset_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tdata[skset_pkg::OPCODE_W-1:0]),
    .in_key    (in_tdata[skset_pkg::OPCODE_W +: skset_pkg::KEY_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skset_mem #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    {(skset_pkg::OUT_TDATA_W - skset_pkg::COUNT_W - 2){1'b0}},
    out_res_r.count, out_res_r.full, out_res_r.success
  };

  // A failed insert on a full store never reports success
  a_full_not_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res_r.full && out_res_r.success))
    else $error("full and success both set");

  // Reported count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_res_r.count) <= CAPACITY))
    else $error("entry count above capacity");

  // One item at a time: no new item right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  // Memory is never written while waiting for a new item
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mem_we)
    else $error("memory write while idle");

endmodule

[tb/skset_checker.sv]
// Checker for the sorted key set: watches both channels, predicts each result and compares.
module skset_checker #(
  parameter int CAPACITY = skset_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [skset_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [skset_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               checked,
  output int                               refused_full,
  output int                               peak_keys
);
  import skset_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [KEY_W-1:0] held_keys[$];   // shadow of the store, ascending
  res_t             awaited[$];     // results still owed by the block
  int               errs;
  int               n_checked;
  int               n_refused;
  int               n_peak;

  // Apply one request to the shadow store and return the result it owes.
  function automatic res_t apply_request(input logic [OPCODE_W-1:0] op,
                                         input logic [KEY_W-1:0] key);
    int   pos = 0;
    bit   hit;
    res_t r;
    while (pos < held_keys.size() && held_keys[pos] < key) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == key);
    r = '0;
    case (op)
      OP_MEMBER: r.success = hit;
      OP_INSERT: begin
        if (!hit) begin
          if (held_keys.size() >= CAPACITY) begin
            r.full = 1'b1;
          end else begin
            held_keys.insert(pos, key);
            r.success = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (hit) begin
          held_keys.delete(pos);
          r.success = 1'b1;
        end
      end
      default: ;  // unused opcode: no change
    endcase
    r.count = COUNT_W'(held_keys.size());
    return r;
  endfunction

  function automatic void note_failure(input string what);
    errs++;
    if (errs <= REPORT_MAX)
      $display("[%0t] ERROR: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      held_keys.delete();
      awaited.delete();
    end else begin
      // Result side first: a same-edge request can never own this result.
      if (out_tvalid && out_tready) begin
        got.success = out_tdata[0];
        got.full    = out_tdata[1];
        got.count   = out_tdata[8:2];
        if (awaited.size() == 0) begin
          note_failure($sformatf("result with nothing expected: success=%0d full=%0d count=%0d",
                                 got.success, got.full, got.count));
        end else begin
          want = awaited.pop_front();
          n_checked++;
          if (got !== want || out_tdata[OUT_TDATA_W-1:9] !== '0)
            note_failure($sformatf(
              "result %0d: expected success=%0d full=%0d count=%0d pad=0, got success=%0d full=%0d count=%0d pad=%0h",
              n_checked, want.success, want.full, want.count,
              got.success, got.full, got.count, out_tdata[OUT_TDATA_W-1:9]));
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(in_tdata[OPCODE_W-1:0], in_tdata[OPCODE_W+KEY_W-1:OPCODE_W]);
        if (want.full) n_refused++;
        if (held_keys.size() > n_peak) n_peak = held_keys.size();
        awaited.push_back(want);
      end
    end
    fail_count   <= errs;
    pending      <= awaited.size();
    checked      <= n_checked;
    refused_full <= n_refused;
    peak_keys    <= n_peak;
  end

endmodule

[tb/testbench.sv]
// Top of the sorted key set testbench: clock, reset, request stimulus, pacing and verdict.
module testbench;
  import skset_pkg::*;

  // Opcode the block has no operation for; it must answer with a plain count.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 160;  // longer than the slowest item
  localparam int RECENT_MAX   = 128;  // keys remembered for hits and repeats

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;

  int fail_count;
  int pending;
  int checked;
  int refused_full;
  int peak_keys;

  // Pacing: sender gap and receiver stall odds, in percent
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit long_hold  = 1'b0;
  int sent_count = 0;
  int n_member   = 0;
  int n_insert   = 0;
  int n_delete   = 0;
  int n_unused   = 0;

  // Keys sent lately: source of hits for queries and deletes, and of repeat inserts
  logic [KEY_W-1:0] recent_keys[$];

  sorted_key_set_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  skset_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .refused_full (refused_full),
    .peak_keys    (peak_keys)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls per phase, forced low during the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long hold-off while the sender keeps offering: the block fills its
  // output register, then holds the next result and drops in_tready.
  initial begin
    wait (sent_count >= 100);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Pacing phases rotate every 50 items: none, sender gaps, receiver stalls, both.
  function automatic void pick_pace();
    case ((sent_count / 50) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 69; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 69; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  // tvalid stays high into the next item unless a gap is drawn.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
    pick_pace();
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);  // junk while idle
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-OPCODE_W-KEY_W){1'b0}}, key, op};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    case (op)
      OP_MEMBER: n_member++;
      OP_INSERT: n_insert++;
      OP_DELETE: n_delete++;
      default:   n_unused++;
    endcase
  endtask

  // Draw a key: often one sent lately, sometimes an extreme, else anything.
  function automatic logic [KEY_W-1:0] choose_key(input int recent_pct);
    int               r = $urandom_range(99);
    logic [KEY_W-1:0] k;
    if (recent_keys.size() > 0 && r < recent_pct) begin
      k = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end else if (r >= 90) begin
      case ($urandom_range(3))
        0: k = '0;
        1: k = '1;
        2: k = {1'b1, {(KEY_W-1){1'b0}}};
        default: k = {1'b0, {(KEY_W-1){1'b1}}};
      endcase
    end else begin
      k = KEY_W'($urandom);
    end
    recent_keys.push_back(k);
    if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
    return k;
  endfunction

  // One random stretch with given insert / delete odds; queries fill the
  // rest, and a rare unused opcode rides along as noise.
  task automatic run_round(input int items, input int ins_pct, input int del_pct);
    int               r;
    logic [OPCODE_W-1:0] op;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct)                op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else if (r < 98)                op = OP_MEMBER;
      else                            op = OP_UNUSED;
      // Inserts lean to new keys, the rest to keys likely held
      key = choose_key(op == OP_INSERT ? 30 : 75);
      send_request(op, key);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extremes, repeats, misses, unused opcode
    send_request(OP_MEMBER, 16'h0000);  // query on empty store
    send_request(OP_DELETE, 16'h0000);  // delete on empty store
    send_request(OP_UNUSED, 16'h0005);  // no-op on empty store
    send_request(OP_INSERT, 16'h0000);  // lowest key
    send_request(OP_INSERT, 16'hFFFF);  // highest key
    send_request(OP_INSERT, 16'h0000);  // already held
    send_request(OP_MEMBER, 16'h0000);
    send_request(OP_MEMBER, 16'hFFFF);
    send_request(OP_MEMBER, 16'h0001);  // absent, between held keys
    send_request(OP_INSERT, 16'h8000);
    send_request(OP_INSERT, 16'h5555);  // alternating bits both ways
    send_request(OP_INSERT, 16'hAAAA);
    send_request(OP_INSERT, 16'h7FFF);
    send_request(OP_MEMBER, 16'hAAAA);
    send_request(OP_UNUSED, 16'hFFFF);  // no-op with entries held
    send_request(OP_DELETE, 16'h5555);  // from the middle
    send_request(OP_DELETE, 16'h5555);  // no longer held
    send_request(OP_DELETE, 16'hFFFF);  // tail entry
    send_request(OP_DELETE, 16'h0000);  // head entry
    send_request(OP_INSERT, 16'h0001);  // new head
    send_request(OP_MEMBER, 16'h5555);

    // Random: fill past capacity (refused inserts, repeats on a full store),
    // drain, mix, then fill again
    run_round(120, 85, 5);
    run_round(100, 10, 75);
    run_round(100, 33, 33);
    run_round(90, 85, 5);
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d queries, %0d inserts, %0d deletes, %0d unused opcodes",
             sent_count, n_member, n_insert, n_delete, n_unused);
    $display("Store peaked at %0d keys; %0d inserts refused on a full store; %0d results checked",
             peak_keys, refused_full, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/skset_pkg.sv
design/skset_mem.sv
design/skset_ctrl.sv
design/sorted_key_set_core.sv
tb/skset_checker.sv
tb/testbench.sv
